FILE: rtl/core/averaging_voltmeter_display_unit_defines.svh
// Assertion macros shared by the voltmeter display block.
// Each macro takes a label, the clock, the active-low reset, an antecedent,
// a consequent and an error message.
`ifndef AVERAGING_VOLTMETER_DISPLAY_UNIT_DEFINES_SVH
`define AVERAGING_VOLTMETER_DISPLAY_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AVD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AVD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/avd_pkg.sv
package avd_pkg;

    // Converter reading width.
    localparam int unsigned SAMPLE_W = 10;
    // Seven-segment pattern width and stored BCD width (two tens bits, four units bits).
    localparam int unsigned SEG_W = 7;
    localparam int unsigned BCD_W = 6;
    localparam int unsigned VOLT_W = 6;

    // Default block length of the running average.
    localparam int unsigned SAMPLES_PER_AVERAGE_DEF = 8;

    // Full scale is 1023 counts for 3.3 V, so avg*33/1023 equals avg/31.
    localparam int unsigned SCALE_DIV = 31;

    // Request kinds.
    localparam logic CMD_SAMPLE  = 1'b0;
    localparam logic CMD_REFRESH = 1'b1;

    // Seven-segment pattern of one decimal digit, bit 0 is segment a.
    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
        logic [SEG_W-1:0] seg;
        unique case (digit)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

    // Two-digit BCD of a value in tenths of a volt (at most 33).
    function automatic logic [BCD_W-1:0] bcd_of(input logic [VOLT_W-1:0] v);
        logic [1:0]        tens;
        logic [VOLT_W-1:0] ones;
        priority if (v >= VOLT_W'(30)) begin
            tens = 2'd3;
            ones = v - VOLT_W'(30);
        end else if (v >= VOLT_W'(20)) begin
            tens = 2'd2;
            ones = v - VOLT_W'(20);
        end else if (v >= VOLT_W'(10)) begin
            tens = 2'd1;
            ones = v - VOLT_W'(10);
        end else begin
            tens = 2'd0;
            ones = v;
        end
        return {tens, ones[3:0]};
    endfunction

endpackage

FILE: rtl/core/avd_if.sv
// Request channel: a converter sample or a display refresh tick.
interface avd_in_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [avd_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output cmd, output sample, input ready);
    modport sink   (input valid, input cmd, input sample, output ready);
endinterface

// Result channel: one display drive or one voltage update.
interface avd_out_if;
    logic                          valid;
    logic                          ready;
    logic [avd_pkg::SEG_W-1:0]     segments;
    logic                          low_digit_on;
    logic                          high_digit_on;
    logic [avd_pkg::BCD_W-1:0]     voltage_bcd;
    logic                          voltage_updated;

    modport source (output valid, output segments, output low_digit_on, output high_digit_on,
                    output voltage_bcd, output voltage_updated, input ready);
    modport sink   (input valid, input segments, input low_digit_on, input high_digit_on,
                    input voltage_bcd, input voltage_updated, output ready);
endinterface

FILE: rtl/core/avd_scale.sv
module avd_scale #(
    parameter int unsigned SAMPLES_PER_AVERAGE = avd_pkg::SAMPLES_PER_AVERAGE_DEF
) (
    input  logic [avd_pkg::SAMPLE_W+$clog2(SAMPLES_PER_AVERAGE)-1:0] i_sum,
    output logic [avd_pkg::BCD_W-1:0]                                o_bcd
);

    localparam int unsigned SUM_W = avd_pkg::SAMPLE_W + $clog2(SAMPLES_PER_AVERAGE);
    // floor(floor(sum/N)/31) equals floor(sum/(31*N)).
    localparam int unsigned DIV   = avd_pkg::SCALE_DIV * SAMPLES_PER_AVERAGE;
    localparam int unsigned SHIFT = SUM_W + $clog2(DIV);
    localparam int unsigned MUL_W = SUM_W + 1;
    localparam int unsigned RECIP = ((2 ** SHIFT) + DIV - 1) / DIV;
    localparam int unsigned PROD_W = SUM_W + MUL_W;

    logic [MUL_W-1:0]            c_recip;
    logic [PROD_W-1:0]           prod;
    logic [avd_pkg::VOLT_W-1:0]  volts;

    // The rounded-up reciprocal gives the exact quotient for every sum of SUM_W bits.
    assign c_recip = MUL_W'(RECIP);
    assign prod    = PROD_W'(i_sum) * PROD_W'(c_recip);
    assign volts   = prod[SHIFT +: avd_pkg::VOLT_W];
    assign o_bcd   = avd_pkg::bcd_of(volts);

endmodule

FILE: rtl/core/averaging_voltmeter_display_unit.sv
// Averaging voltmeter with two-digit seven-segment display drive.
// Throughput: one request per cycle, with no stall unless the result side stalls.
// Each request passes in turn through the input register, the accumulate stage and the result register;
// a sample that does not end a block produces no result.
// Reset: synchronous, active low; clears the pipeline, the running sum and the stored voltage.
`include "averaging_voltmeter_display_unit_defines.svh"

module averaging_voltmeter_display_unit #(
    parameter int unsigned SAMPLES_PER_AVERAGE = avd_pkg::SAMPLES_PER_AVERAGE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    avd_in_if.sink     i_in,
    avd_out_if.source  o_out
);

    // The sum of one block needs log2 of the block length more bits than a sample.
    localparam int unsigned SUM_W    = avd_pkg::SAMPLE_W + $clog2(SAMPLES_PER_AVERAGE);
    localparam int unsigned CNT_W    = (SAMPLES_PER_AVERAGE > 1) ?
                                       $clog2(SAMPLES_PER_AVERAGE) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_AVERAGE - 1);

    // Input register.
    logic                          r_a_valid;
    logic                          r_a_cmd;
    logic [avd_pkg::SAMPLE_W-1:0]  r_a_sample;

    // Running block of samples.
    logic [SUM_W-1:0]              r_sum;
    logic [CNT_W-1:0]              r_count;
    logic [SUM_W-1:0]              n_sum;
    logic [CNT_W-1:0]              n_count;

    // Accumulate stage: a refresh request or a finished block sum.
    logic                          r_b_valid;
    logic                          r_b_upd;
    logic [SUM_W-1:0]              r_b_sum;

    // Display state.
    logic [avd_pkg::BCD_W-1:0]     r_stored_bcd;
    logic                          r_show_high;

    // Result register.
    logic                          r_o_valid;
    logic [avd_pkg::SEG_W-1:0]     r_o_segments;
    logic                          r_o_low;
    logic                          r_o_high;
    logic [avd_pkg::BCD_W-1:0]     r_o_bcd;
    logic                          r_o_upd;

    logic                          o_free;
    logic                          b_free;
    logic                          a_free;
    logic                          a_adv;
    logic                          b_adv;
    logic                          block_done;
    logic [SUM_W-1:0]              acc_sum;
    logic [avd_pkg::BCD_W-1:0]     scaled_bcd;
    logic [3:0]                    shown_digit;

    // Each stage may take a new request when it is empty or when its contents move on
    // in the same cycle, so empty stages behind a waiting result can still fill.
    assign o_free = !r_o_valid || o_out.ready;
    assign b_free = !r_b_valid || o_free;
    assign a_free = !r_a_valid || b_free;
    assign a_adv  = r_a_valid && b_free;
    assign b_adv  = r_b_valid && o_free;

    assign i_in.ready = a_free;

    // The sample in the input register is added as it leaves; the block is complete
    // when the count has reached its last value.
    assign acc_sum    = r_sum + SUM_W'(r_a_sample);
    assign block_done = (r_a_cmd == avd_pkg::CMD_SAMPLE) && (r_count == LAST_CNT);

    always_comb begin
        n_sum   = r_sum;
        n_count = r_count;
        if (a_adv && (r_a_cmd == avd_pkg::CMD_SAMPLE)) begin
            if (block_done) begin
                n_sum   = '0;
                n_count = '0;
            end else begin
                n_sum   = acc_sum;
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    // Average and scaling to tenths of a volt, as one constant multiplication.
    avd_scale #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
    ) u_scale (
        .i_sum (r_b_sum),
        .o_bcd (scaled_bcd)
    );

    // Units digit first after reset; the tens digit has only two stored bits.
    assign shown_digit = r_show_high ? {2'b00, r_stored_bcd[5:4]} : r_stored_bcd[3:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid    <= 1'b0;
            r_sum        <= '0;
            r_count      <= '0;
            r_b_valid    <= 1'b0;
            r_stored_bcd <= '0;
            r_show_high  <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (a_free) begin
                r_a_valid <= i_in.valid;
            end

            r_sum   <= n_sum;
            r_count <= n_count;

            // Samples that do not finish a block leave no trace beyond the accumulator.
            if (b_free) begin
                r_b_valid <= a_adv && ((r_a_cmd == avd_pkg::CMD_REFRESH) || block_done);
            end

            if (o_free) begin
                r_o_valid <= r_b_valid;
            end

            // The stored voltage and the digit toggle change as their request reaches the
            // result register, so a refresh always sees every update accepted before it.
            if (b_adv) begin
                if (r_b_upd) begin
                    r_stored_bcd <= scaled_bcd;
                end else begin
                    r_show_high <= !r_show_high;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && a_free) begin
            r_a_cmd    <= i_in.cmd;
            r_a_sample <= i_in.sample;
        end
        if (b_free) begin
            r_b_upd <= block_done;
            r_b_sum <= acc_sum;
        end
        if (b_adv) begin
            if (r_b_upd) begin
                r_o_segments <= '0;
                r_o_low      <= 1'b0;
                r_o_high     <= 1'b0;
                r_o_bcd      <= scaled_bcd;
                r_o_upd      <= 1'b1;
            end else begin
                r_o_segments <= avd_pkg::seg_of(shown_digit);
                r_o_low      <= !r_show_high;
                r_o_high     <= r_show_high;
                r_o_bcd      <= r_stored_bcd;
                r_o_upd      <= 1'b0;
            end
        end
    end

    assign o_out.valid           = r_o_valid;
    assign o_out.segments        = r_o_segments;
    assign o_out.low_digit_on    = r_o_low;
    assign o_out.high_digit_on   = r_o_high;
    assign o_out.voltage_bcd     = r_o_bcd;
    assign o_out.voltage_updated = r_o_upd;

    // A refresh result drives exactly one digit.
    `AVD_ASSERT_NOW(a_one_digit, i_clk, i_rst_n, r_o_valid && !r_o_upd, $onehot({r_o_low, r_o_high}), "refresh result must enable exactly one digit")
    // The stored units digit is always a decimal digit.
    `AVD_ASSERT_NOW(a_bcd_units, i_clk, i_rst_n, 1'b1, r_stored_bcd[3:0] <= 4'd9, "stored units digit above nine")
    // Finishing a block empties the accumulator.
    `AVD_ASSERT_NEXT(a_block_clear, i_clk, i_rst_n, a_adv && block_done, (r_sum == '0) && (r_count == '0), "accumulator not cleared after a finished block")

endmodule
